@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked on every rising edge, held off while reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/core/hcbe_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbe_pkg
// Types and constants of the Huffman codebook build and encode unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbe_pkg;

  localparam int MaxCodeLen = 32;
  localparam int NumSymbols = 256;
  localparam int PathWidth  = 32;
  localparam int DepthLimit = (MaxCodeLen < PathWidth) ? MaxCodeLen : PathWidth;

  localparam int SymWidth   = 8;
  localparam int SymAddrW   = (NumSymbols > 1) ? $clog2(NumSymbols) : 1;
  localparam int LenWidth   = 6;
  localparam int EntryWidth = PathWidth + LenWidth;

  localparam int InDataW    = 8;
  localparam int InUserW    = 2;
  localparam int OutFieldsW = PathWidth + LenWidth + 1 + 2;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_NODE  = 2'd1,
    KIND_LEAF  = 2'd2,
    KIND_DATA  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_IGNORED = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_e;

  // word held between the accept stage and the result register
  typedef struct packed {
    logic                  is_data;
    logic                  hit;
    logic [PathWidth-1:0]  code;
    logic [LenWidth-1:0]   len;
    status_e               status;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/core/hcbe_ram.sv @@
// ----------------------------------------------------------------------------
// hcbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/huffman_codebook_build_and_encode_unit.sv @@
// Path: an accepted word passes the lookup stage, then the result register.
// Throughput: one word per cycle unless the output stalls; the codebook RAM read is
// registered, so the lookup occupies one stage and the result register the next.
// Reset: path, depth, tree-complete flag and symbol valid bits clear at once;
// the codebook RAM is not cleared, entries are gated by their valid bits.
// ----------------------------------------------------------------------------
// huffman_codebook_build_and_encode_unit
// Builds a codebook from a preorder tree token stream and encodes bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module huffman_codebook_build_and_encode_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [hcbe_pkg::InDataW-1:0]    s_axis_tdata,  // [7:0] symbol
  input  wire logic [hcbe_pkg::InUserW-1:0]    s_axis_tuser,  // [1:0] kind
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [31:0] code, [37:32] code_length, [38] hit, [40:39] status, rest zero
  output logic [hcbe_pkg::OutDataW-1:0]        m_axis_tdata
);

  localparam int PW = hcbe_pkg::PathWidth;
  localparam int LW = hcbe_pkg::LenWidth;
  localparam int AW = hcbe_pkg::SymAddrW;

  logic [PW-1:0]              path_q, path_d;
  logic [LW-1:0]              depth_q, depth_d;
  logic                       done_q, done_d;
  logic [hcbe_pkg::NumSymbols-1:0] vmap_q, vmap_d;

  logic                       s1_valid_q;
  hcbe_pkg::stage_t           s1_q, s1_d;
  logic                       out_valid_q;
  logic [hcbe_pkg::OutFieldsW-1:0] out_q, out_d;

  logic                       in_acc, advance;
  hcbe_pkg::kind_e            kind;
  logic [hcbe_pkg::SymWidth-1:0] sym;
  logic                       sym_ok;
  logic [AW-1:0]              sym_addr;

  logic [LW-1:0]              tones;
  logic [LW-1:0]              adv_depth;
  logic [PW-1:0]              adv_path;

  logic                       ram_we;
  logic [hcbe_pkg::EntryWidth-1:0] ram_rdata;

  assign kind     = hcbe_pkg::kind_e'(s_axis_tuser);
  assign sym      = s_axis_tdata[hcbe_pkg::SymWidth-1:0];
  assign sym_ok   = {1'b0, sym} < (hcbe_pkg::SymWidth + 1)'(hcbe_pkg::NumSymbols);
  assign sym_addr = sym[AW-1:0];

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // trailing ones of the live path bits: position of the lowest bit that breaks the run
  always_comb begin
    tones = LW'(PW);
    for (int i = PW - 1; i >= 0; i--) begin
      if (!((LW'(i) < depth_q) && path_q[i])) begin
        tones = LW'(i);
      end
    end
    adv_depth = depth_q - tones;
    adv_path  = (path_q >> tones) | PW'(1);
  end

  always_comb begin
    path_d  = path_q;
    depth_d = depth_q;
    done_d  = done_q;
    vmap_d  = vmap_q;
    ram_we  = 1'b0;
    s1_d    = '{is_data: 1'b0, hit: 1'b0, code: '0, len: '0,
                status: hcbe_pkg::STATUS_OK};
    case (kind)
      hcbe_pkg::KIND_START: begin
        path_d  = '0;
        depth_d = '0;
        done_d  = 1'b0;
        vmap_d  = '0;
      end
      hcbe_pkg::KIND_DATA: begin
        s1_d.is_data = 1'b1;
        s1_d.hit     = sym_ok && vmap_q[sym_addr];
      end
      hcbe_pkg::KIND_NODE: begin
        if (done_q) begin
          s1_d.status = hcbe_pkg::STATUS_IGNORED;
        end else if (depth_q >= LW'(hcbe_pkg::DepthLimit)) begin
          s1_d.status = hcbe_pkg::STATUS_TOO_LONG;
        end else begin
          path_d  = path_q << 1;
          depth_d = depth_q + 1'b1;
        end
      end
      hcbe_pkg::KIND_LEAF: begin
        if (done_q) begin
          s1_d.status = hcbe_pkg::STATUS_IGNORED;
        end else begin
          s1_d.code = path_q;
          s1_d.len  = depth_q;
          if (sym_ok) begin
            ram_we           = 1'b1;
            vmap_d[sym_addr] = 1'b1;
          end
          depth_d = adv_depth;
          if (adv_depth == '0) begin
            path_d = '0;
            done_d = 1'b1;
          end else begin
            path_d = adv_path;
          end
        end
      end
      default: begin
        s1_d.status = hcbe_pkg::STATUS_OK;
      end
    endcase
  end

  hcbe_ram #(
    .Width (hcbe_pkg::EntryWidth),
    .Depth (hcbe_pkg::NumSymbols)
  ) u_book (
    .clk_i   (clk_i),
    .we_i    (in_acc && ram_we),
    .waddr_i (sym_addr),
    .wdata_i ({depth_q, path_q}),
    .re_i    (in_acc),
    .raddr_i (sym_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (s1_q.is_data && s1_q.hit) begin
      out_d = {hcbe_pkg::STATUS_OK, 1'b1, ram_rdata};
    end else if (s1_q.is_data) begin
      out_d = {hcbe_pkg::STATUS_OK, 1'b0, LW'(0), PW'(0)};
    end else begin
      out_d = {s1_q.status, 1'b0, s1_q.len, s1_q.code};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_q      <= '0;
      depth_q     <= '0;
      done_q      <= 1'b0;
      vmap_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        path_q  <= path_d;
        depth_q <= depth_d;
        done_q  <= done_d;
        vmap_q  <= vmap_d;
      end
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (advance && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(hcbe_pkg::OutDataW - hcbe_pkg::OutFieldsW)'(0), out_q};

  `ASSERT_CLK(a_depth_in_range, clk_i, rst_ni,
              depth_q <= LW'(hcbe_pkg::DepthLimit),
              "path depth beyond limit")
  `ASSERT_CLK(a_done_path_clear, clk_i, rst_ni,
              done_q |-> (depth_q == '0 && path_q == '0),
              "tree complete with live path")
  `ASSERT_CLK(a_full_stall, clk_i, rst_ni,
              (s1_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready,
              "input taken while both stages stalled")
  `ASSERT_CLK(a_hit_ok, clk_i, rst_ni,
              (m_axis_tvalid && m_axis_tdata[PW+LW]) |->
                (m_axis_tdata[PW+LW+2:PW+LW+1] == hcbe_pkg::STATUS_OK),
              "hit reported with non-ok status")
  `ASSERT_ALWAYS(a_reset_clears, clk_i,
                 !rst_ni |=> (!s1_valid_q && !out_valid_q) || rst_ni,
                 "pipeline not empty after reset")

endmodule

`default_nettype wire
